// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules.
// Depends on nothing; taken in by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/tsc_pkg.sv =====
// Shared widths, constants and the lane type of the Taylor sine/cosine block.
// Depends on nothing; imported by every module of the block.
package tsc_pkg;

    localparam int FRAC_BITS = 28;
    localparam int MAX_TERMS = 8;

    localparam int TC_W     = 4;
    localparam int TC_RESET = 7;
    localparam int ANG_W    = 16;
    localparam int VAL_W    = 32;

    // angle reduction by 360
    localparam int DEG_MOD = 360;
    localparam int MAG_W   = 9;
    localparam int RQ_SH   = 16;
    localparam int RQ_M    = (1 << RQ_SH) / DEG_MOD;
    localparam int RQ_M_W  = 8;
    localparam int RQ_W    = 7;

    // degrees to radians: 3.14159 / 180 with the power of two taken out of 18000000
    localparam longint PI_NUM     = 314159;
    localparam longint PI_DEN_ODD = 140625;
    localparam longint PI_HALF    = 70312;
    localparam longint PI_K       = PI_NUM * (longint'(1) << (FRAC_BITS - 7));
    localparam longint PI_Q       = PI_K / PI_DEN_ODD;
    localparam longint PI_R       = PI_K % PI_DEN_ODD;
    localparam int     PQ_W       = FRAC_BITS - 5;
    localparam int     PR_W       = 18;
    localparam int     V_W        = 26;
    localparam int     D_SH       = V_W + 1;
    localparam longint DM         = (longint'(1) << D_SH) / PI_DEN_ODD;
    localparam int     DM_W       = 10;
    localparam int     DQ_W       = 9;

    // series datapath
    localparam int AX_W   = FRAC_BITS + 3;
    localparam int T_W    = FRAC_BITS + 11;
    localparam int SUM_W  = FRAC_BITS + 12;
    localparam int ML_W   = (T_W + 1) / 2;
    localparam int MH_W   = T_W - ML_W;
    localparam int PROD_W = T_W + AX_W;
    localparam int N_W    = $clog2(2 * MAX_TERMS + 1);
    localparam int IDX_W  = TC_W;

    localparam int DIV_CHUNK = 8;
    localparam int DIV_STEPS = (T_W + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int DIV_W     = DIV_STEPS * DIV_CHUNK;
    localparam int DIV_LAST  = DIV_STEPS - 1;

    localparam logic [T_W-1:0]    T_ONE  = T_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] P_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

    typedef struct packed {
        logic                    neg;
        logic [AX_W-1:0]         ax;
        logic [T_W-1:0]          t;
        logic [N_W-1:0]          n;
        logic [IDX_W-1:0]        idx;
        logic signed [SUM_W-1:0] sum;
    } t_lane;

endpackage

// ===== hw/rtl/tsc_front.sv =====
// Front end: reduces the angle modulo 360, converts it to radians and seeds term 0.
// Depends on tsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic                          i_cmd,
    input  logic signed [tsc_pkg::ANG_W-1:0] i_angle_deg,
    input  logic [tsc_pkg::TC_W-1:0]      i_term_count,
    output logic                          o_vld,
    output tsc_pkg::t_lane                o_lane
);
    import tsc_pkg::*;

    logic [6:0] r_vld;
    logic [5:0] r_cmd_sr;
    logic [5:0] r_neg_sr;

    logic [ANG_W-1:0] s1_abs;
    logic [ANG_W-1:0] r_s1_abs;
    logic [ANG_W-1:0] r_s2_abs;
    logic [RQ_W-1:0]  r_s2_q;
    logic [MAG_W-1:0] r_s3_mag;
    logic [AX_W-1:0]  r_s4_p;
    logic [V_W-1:0]   r_s4_v;
    logic [AX_W-1:0]  r_s5_p;
    logic [V_W-1:0]   r_s5_v;
    logic [DQ_W-1:0]  r_s5_q;
    logic [AX_W-1:0]  r_s6_ax;
    t_lane            r_lane;

    logic [ANG_W+RQ_M_W-1:0] s2_prod;
    logic [ANG_W-1:0]        s3_qm;
    logic [ANG_W-1:0]        s3_r;
    logic [MAG_W-1:0]        n_s3_mag;
    logic [MAG_W+PQ_W-1:0]   s4_p_full;
    logic [V_W-1:0]          s4_v;
    logic [V_W+DM_W-1:0]     s5_prod;
    logic [V_W-1:0]          s6_qd;
    logic [V_W-1:0]          s6_r;
    logic                    s6_inc;
    logic [AX_W-1:0]         n_s6_ax;
    logic                    s7_cmd;
    logic                    s7_tneg;
    logic [T_W-1:0]          s7_t0;
    logic signed [SUM_W-1:0] s7_t;
    t_lane                   n_lane;

    assign s1_abs = i_angle_deg[ANG_W-1] ? ANG_W'(-i_angle_deg) : ANG_W'(i_angle_deg);

    assign s2_prod = r_s1_abs * RQ_M_W'(RQ_M);

    assign s3_qm    = {{(ANG_W - RQ_W){1'b0}}, r_s2_q} * ANG_W'(DEG_MOD);
    assign s3_r     = r_s2_abs - s3_qm;
    assign n_s3_mag = (s3_r >= ANG_W'(DEG_MOD)) ? MAG_W'(s3_r - ANG_W'(DEG_MOD))
                                                : s3_r[MAG_W-1:0];

    assign s4_p_full = r_s3_mag * PQ_W'(PI_Q);
    assign s4_v      = r_s3_mag * PR_W'(PI_R) + V_W'(PI_HALF);

    assign s5_prod = r_s4_v * DM_W'(DM);

    assign s6_qd   = r_s5_q * V_W'(PI_DEN_ODD);
    assign s6_r    = r_s5_v - s6_qd;
    assign s6_inc  = s6_r >= V_W'(PI_DEN_ODD);
    assign n_s6_ax = r_s5_p + AX_W'(r_s5_q) + AX_W'(s6_inc);

    assign s7_cmd  = r_cmd_sr[5];
    assign s7_tneg = r_neg_sr[5] & ~s7_cmd;
    assign s7_t0   = s7_cmd ? T_ONE : {{(T_W - AX_W){1'b0}}, r_s6_ax};
    assign s7_t    = $signed({{(SUM_W - T_W){1'b0}}, s7_t0});

    always_comb begin
        n_lane     = '0;
        n_lane.neg = r_neg_sr[5];
        n_lane.ax  = r_s6_ax;
        n_lane.t   = s7_t0;
        n_lane.n   = {{(N_W - 1){1'b0}}, ~s7_cmd};
        n_lane.idx = '0;
        if (i_term_count != '0) begin
            n_lane.sum = s7_tneg ? -s7_t : s7_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd_sr <= {r_cmd_sr[4:0], i_cmd};
            r_neg_sr <= {r_neg_sr[4:0], i_angle_deg[ANG_W-1]};
            r_s1_abs <= s1_abs;
            r_s2_abs <= r_s1_abs;
            r_s2_q   <= s2_prod[RQ_SH +: RQ_W];
            r_s3_mag <= n_s3_mag;
            r_s4_p   <= s4_p_full[AX_W-1:0];
            r_s4_v   <= s4_v;
            r_s5_p   <= r_s4_p;
            r_s5_v   <= r_s4_v;
            r_s5_q   <= s5_prod[D_SH +: DQ_W];
            r_s6_ax  <= n_s6_ax;
            r_lane   <= n_lane;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_lane = r_lane;

    `ASSERT_CLK(a_mag_range, i_clk, i_rst_n, r_vld[2] |-> (r_s3_mag < MAG_W'(DEG_MOD)), "reduced angle out of range")

endmodule

// ===== hw/rtl/tsc_step.sv =====
// One power step: rounded fixed-point multiply by x, then divide by n+1.
// Depends on tsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsc_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  tsc_pkg::t_lane i_lane,
    output logic           o_vld,
    output tsc_pkg::t_lane o_lane
);
    import tsc_pkg::*;

    logic                   r_m1_vld;
    t_lane                  r_m1_lane;
    logic [ML_W+AX_W-1:0]   r_m1_pl;
    logic                   r_m2_vld;
    t_lane                  r_m2_lane;
    logic [T_W-1:0]         r_m2_v;

    logic [DIV_STEPS-1:0]   r_dv;
    t_lane                  r_dl [DIV_STEPS];
    logic [DIV_W-1:0]       r_dw [DIV_STEPS];
    logic [N_W-1:0]         r_dr [DIV_STEPS];
    t_lane                  n_dl [DIV_STEPS];
    logic [DIV_W-1:0]       n_dw [DIV_STEPS];
    logic [N_W-1:0]         n_dr [DIV_STEPS];

    logic [ML_W+AX_W-1:0]   m1_pl;
    logic [MH_W+AX_W-1:0]   m2_ph;
    logic [PROD_W-1:0]      m2_full;
    logic [N_W-1:0]         last_d;

    assign m1_pl   = i_lane.t[ML_W-1:0] * i_lane.ax;
    assign m2_ph   = r_m1_lane.t[T_W-1:ML_W] * r_m1_lane.ax;
    assign m2_full = {m2_ph, {ML_W{1'b0}}} + PROD_W'(r_m1_pl) + P_HALF;

    always_comb begin
        logic [N_W:0]           sh;
        logic [N_W-1:0]         d;
        logic [N_W-1:0]         rem;
        logic [DIV_CHUNK-1:0]   q;
        logic [DIV_W-1:0]       w_in;
        t_lane                  l_in;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                w_in = DIV_W'(r_m2_v);
                rem  = '0;
                l_in = r_m2_lane;
            end else begin
                w_in = r_dw[k-1];
                rem  = r_dr[k-1];
                l_in = r_dl[k-1];
            end
            d = l_in.n + 1'b1;
            q = '0;
            for (int j = 0; j < DIV_CHUNK; j++) begin
                sh = {rem, w_in[DIV_W-1-j]};
                if (sh >= {1'b0, d}) begin
                    sh = sh - {1'b0, d};
                    q[DIV_CHUNK-1-j] = 1'b1;
                end
                rem = sh[N_W-1:0];
            end
            n_dw[k] = {w_in[DIV_W-DIV_CHUNK-1:0], q};
            n_dr[k] = rem;
            n_dl[k] = l_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_dv     <= '0;
        end else if (i_en) begin
            r_m1_vld <= i_vld;
            r_m2_vld <= r_m1_vld;
            r_dv     <= {r_dv[DIV_STEPS-2:0], r_m2_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_lane <= i_lane;
            r_m1_pl   <= m1_pl;
            r_m2_lane <= r_m1_lane;
            r_m2_v    <= m2_full[FRAC_BITS +: T_W];
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dl[k] <= n_dl[k];
                r_dw[k] <= n_dw[k];
                r_dr[k] <= n_dr[k];
            end
        end
    end

    assign last_d = r_dl[DIV_LAST].n + 1'b1;

    always_comb begin
        o_lane   = r_dl[DIV_LAST];
        o_lane.t = r_dw[DIV_LAST][T_W-1:0];
        o_lane.n = last_d;
    end

    assign o_vld = r_dv[DIV_LAST];

    `ASSERT_CLK(a_div_rem, i_clk, i_rst_n, r_dv[DIV_LAST] |-> (r_dr[DIV_LAST] < last_d), "divider remainder not below divisor")

endmodule

// ===== hw/rtl/tsc_cell.sv =====
// Series cell: two power steps give the next term, summed if its idx < term_count.
// Depends on tsc_pkg and tsc_step.
module tsc_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [tsc_pkg::TC_W-1:0] i_term_count,
    input  logic                     i_vld,
    input  tsc_pkg::t_lane           i_lane,
    output logic                     o_vld,
    output tsc_pkg::t_lane           o_lane
);
    import tsc_pkg::*;

    logic                    a_vld;
    t_lane                   a_lane;
    logic                    b_vld;
    t_lane                   b_lane;
    logic                    r_vld;
    t_lane                   r_lane;

    logic [IDX_W-1:0]        add_idx;
    logic                    add_neg;
    logic signed [SUM_W-1:0] add_t;
    t_lane                   n_lane;

    tsc_step u_step_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (i_vld),
        .i_lane  (i_lane),
        .o_vld   (a_vld),
        .o_lane  (a_lane)
    );

    tsc_step u_step_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (a_vld),
        .i_lane  (a_lane),
        .o_vld   (b_vld),
        .o_lane  (b_lane)
    );

    assign add_idx = b_lane.idx + 1'b1;
    assign add_neg = add_idx[0] ^ (b_lane.neg & b_lane.n[0]);
    assign add_t   = $signed({{(SUM_W - T_W){1'b0}}, b_lane.t});

    always_comb begin
        n_lane     = b_lane;
        n_lane.idx = add_idx;
        if (add_idx < i_term_count) begin
            n_lane.sum = add_neg ? b_lane.sum - add_t : b_lane.sum + add_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;

endmodule

// ===== hw/rtl/taylor_sine_cosine_deg.sv =====
// Top level of the Taylor series sine/cosine unit for whole-degree angles.
// Depends on tsc_pkg, tsc_front, tsc_cell and assert_macros.svh.
//
// Input channel: i_in_valid / o_in_stall carry one word of i_cmd (0 sine, 1 cosine)
// and i_angle_deg. Output channel: o_out_valid / i_out_stall carry o_value, the
// saturated series sum in signed Q3.28. A word moves at an edge with valid high
// and stall low. i_cfg_wr_en / i_cfg_wr_data write term_count (reset value 7).
// Throughput: one word per cycle while o_in_stall is low. Each series cell holds
// two multiply-and-divide steps of seven stages and one accumulate stage, and the
// angle reduction and radian conversion take seven stages.
// Reset clears all valid flags and sets term_count to 7; no clearing pass.
// While i_out_stall holds a valid result, the pipeline still advances as long as
// its last stage is empty, so bubbles close up and inputs keep being taken; once
// a finished word sits behind the stalled output, o_in_stall rises and all holds.
`include "assert_macros.svh"

module taylor_sine_cosine_deg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tsc_pkg::TC_W-1:0]         i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic signed [tsc_pkg::ANG_W-1:0] i_angle_deg,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [tsc_pkg::VAL_W-1:0] o_value
);
    import tsc_pkg::*;

    logic [TC_W-1:0]      r_term_count;
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_value;

    logic [MAX_TERMS-1:0] ch_vld;
    t_lane                ch_lane [MAX_TERMS];

    logic                 pipe_en;
    logic                 out_load;
    logic                 tail_vld;
    logic [SUM_W-1:0]     tail_sum;
    logic                 in_range;
    logic [VAL_W-1:0]     sat_val;

    assign tail_vld = ch_vld[MAX_TERMS-1];
    assign tail_sum = ch_lane[MAX_TERMS-1].sum;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign pipe_en    = out_load || !tail_vld;
    assign o_in_stall = !pipe_en;

    tsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_vld        (i_in_valid),
        .i_cmd        (i_cmd),
        .i_angle_deg  (i_angle_deg),
        .i_term_count (r_term_count),
        .o_vld        (ch_vld[0]),
        .o_lane       (ch_lane[0])
    );

    for (genvar g = 1; g < MAX_TERMS; g++) begin : g_cell
        tsc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (pipe_en),
            .i_term_count (r_term_count),
            .i_vld        (ch_vld[g-1]),
            .i_lane       (ch_lane[g-1]),
            .o_vld        (ch_vld[g]),
            .o_lane       (ch_lane[g])
        );
    end

    assign in_range = (&tail_sum[SUM_W-1:VAL_W-1]) || !(|tail_sum[SUM_W-1:VAL_W-1]);
    assign sat_val  = in_range ? tail_sum[VAL_W-1:0] :
                      (tail_sum[SUM_W-1] ? VAL_MIN : VAL_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TC_W'(TC_RESET);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_term_count <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= tail_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_value <= sat_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    `ASSERT_CLK(a_tail_held, i_clk, i_rst_n, (o_out_valid && i_out_stall && tail_vld) |=> tail_vld, "tail word lost while output stalled")
    `ASSERT_CLK(a_out_drain, i_clk, i_rst_n, (!i_out_stall && !tail_vld) |=> !o_out_valid, "output word repeated after it was taken")
    `ASSERT_NEVER_CLK(a_stall_empty, i_clk, i_rst_n, o_in_stall && !o_out_valid, "input stalled with empty output register")

endmodule
